### design/assert_macros.svh
// assertion macros shared by the display scan design
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked at every clock edge, reset included
`define ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst, prop, msg)
`define ASSERT_ALL(label, clk, prop, msg)
`endif
`endif

### design/ssdscan_pkg.sv
// shared types, constants and the digit image decoder of the display scan block
// no dependencies
package ssdscan_pkg;

   // default number of digit bytes in the store
   localparam int DEFAULT_MAX_DIGITS = 8;

   // bit 7 of a segment byte drives the dot
   localparam int DOT_POS = 7;

   // item kinds carried on req_tuser
   typedef enum logic [2:0] {
      MODE_REFRESH = 3'd0,
      MODE_BCD     = 3'd1,
      MODE_TOGGLE  = 3'd2,
      MODE_SET     = 3'd3,
      MODE_CLEAR   = 3'd4
   } mode_type;

   // register indexes of the write port
   typedef enum logic [1:0] {
      CSR_DIGIT_COUNT  = 2'd0,
      CSR_BLINK_FIRST  = 2'd1,
      CSR_BLINK_LAST   = 2'd2,
      CSR_BLINK_PERIOD = 2'd3
   } csr_index_type;

   // segments A..G for one bcd value, blank above nine
   function automatic logic [6:0] digit_image(input logic [3:0] nib);
      logic [6:0] seg;
      case (nib)
         4'd0: seg = 7'h3F;
         4'd1: seg = 7'h06;
         4'd2: seg = 7'h5B;
         4'd3: seg = 7'h4F;
         4'd4: seg = 7'h66;
         4'd5: seg = 7'h6D;
         4'd6: seg = 7'h7D;
         4'd7: seg = 7'h07;
         4'd8: seg = 7'h7F;
         4'd9: seg = 7'h67;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

endpackage

### design/seven_segment_scan_with_blink_top.sv
// multiplexed seven segment driver with digit blinking, single module
// depends on ssdscan_pkg and assert_macros.svh
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tuser: mode; tdata: bcd, count, dot operand
// rsp      out  rsp_tvalid/rsp_tready  tdata: segment byte, digit number
// csr      in   csr_we                 csr_index, csr_wdata
//
// one word per cycle unless a rsp word is stalled: a taken item updates the store
// (bcd, dot modes) or scan index and blink counter (refresh) at that edge, unless
// csr_we wins; a refresh result is loaded into the output register at that same edge
// and offered from the next cycle. reset (synchronous) empties the store, sets the
// scan to the last digit and clears the blink counter. a stalled rsp word holds the
// output register; req is still taken in that cycle only when the waiting word leaves.
`include "assert_macros.svh"

module seven_segment_scan_with_blink_top
   import ssdscan_pkg::*;
#(
   parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // bcd_digits[31:0], bcd_count[35:32], dot_operand[43:36]
   input  logic [2:0]  req_tuser,  // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // segment_drive[7:0], digit_select[10:8]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int BLINK_MOD = MAX_DIGITS + 1;
   localparam int BCD_LANES = (MAX_DIGITS < 8) ? MAX_DIGITS : 8;
   localparam int RESET_COUNT = (MAX_DIGITS < 8) ? MAX_DIGITS : 8;

   // input word fields
   logic [31:0] bcd_digits;
   logic [3:0]  bcd_count;
   logic [7:0]  dot_operand;
   mode_type    mode;

   assign bcd_digits  = req_tdata[31:0];
   assign bcd_count   = req_tdata[35:32];
   assign dot_operand = req_tdata[43:36];
   assign mode        = mode_type'(req_tuser);

   // state
   logic [7:0]       store_ff [MAX_DIGITS];
   logic [7:0]       store_in [MAX_DIGITS];
   logic [IDX_W-1:0] act_ff, act_in;
   logic [15:0]      bcnt_ff, bcnt_in;
   logic [CNT_W-1:0] dcount_ff, dcount_in;
   logic [CNT_W-1:0] bfirst_ff, bfirst_in;
   logic [CNT_W-1:0] blast_ff, blast_in;
   logic [15:0]      bperiod_ff, bperiod_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] seg_ff, seg_in;
   logic [2:0] dsel_ff, dsel_in;

   logic req_fire;
   logic is_refresh;

   // blink bound reduction, a constant table over the 4-bit write value
   logic [CNT_W-1:0] bound_mod [16];
   for (genvar v = 0; v < 16; v++) begin : g_mod
      assign bound_mod[v] = CNT_W'(v % BLINK_MOD);
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_refresh = (mode == MODE_REFRESH);

   // scan step: next digit, blink counter and shown byte
   logic [CNT_W-1:0] act_inc;
   logic [IDX_W-1:0] act_next;
   logic [16:0]      bcnt_inc;
   logic [15:0]      bcnt_next;
   logic             in_range;
   logic [7:0]       seg_show;

   always_comb begin
      act_inc = CNT_W'(act_ff) + CNT_W'(1);
      if (act_inc >= dcount_ff || act_inc >= CNT_W'(MAX_DIGITS)) begin
         act_next = '0;
      end else begin
         act_next = IDX_W'(act_inc);
      end
      bcnt_inc = {1'b0, bcnt_ff} + 17'd1;
      bcnt_next = bcnt_ff;
      if (bperiod_ff != 16'd0 && act_next == '0) begin
         bcnt_next = (bcnt_inc == {1'b0, bperiod_ff}) ? 16'd0 : bcnt_inc[15:0];
      end
      in_range = (CNT_W'(act_next) >= bfirst_ff) && (CNT_W'(act_next) <= blast_ff);
      seg_show = store_ff[act_next];
      if (bperiod_ff != 16'd0 && in_range && bcnt_next > (bperiod_ff >> 1)) begin
         seg_show = 8'd0;
      end
   end

   // next state of the store and scan registers
   always_comb begin
      store_in   = store_ff;
      act_in     = act_ff;
      bcnt_in    = bcnt_ff;
      dcount_in  = dcount_ff;
      bfirst_in  = bfirst_ff;
      blast_in   = blast_ff;
      bperiod_in = bperiod_ff;

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DIGIT_COUNT: begin
               if (csr_wdata[3:0] == 4'd0) begin
                  dcount_in = CNT_W'(1);
               end else if (csr_wdata[3:0] > MAX_DIGITS) begin
                  dcount_in = CNT_W'(MAX_DIGITS);
               end else begin
                  dcount_in = CNT_W'(csr_wdata[3:0]);
               end
               act_in = IDX_W'(dcount_in - CNT_W'(1));
            end
            CSR_BLINK_FIRST: begin
               bfirst_in = bound_mod[csr_wdata[3:0]];
               bcnt_in   = 16'd0;
            end
            CSR_BLINK_LAST: begin
               blast_in = bound_mod[csr_wdata[3:0]];
               bcnt_in  = 16'd0;
            end
            CSR_BLINK_PERIOD: begin
               bperiod_in = csr_wdata;
               bcnt_in    = 16'd0;
            end
            default: ;
         endcase
      end else if (req_fire) begin
         unique case (mode)
            MODE_REFRESH: begin
               act_in  = act_next;
               bcnt_in = bcnt_next;
            end
            MODE_BCD: begin
               // segments cleared everywhere, dots kept
               for (int i = 0; i < MAX_DIGITS; i++) begin
                  store_in[i][6:0] = 7'd0;
               end
               for (int i = 0; i < BCD_LANES; i++) begin
                  if (i < bcd_count && i < dcount_ff) begin
                     store_in[i][6:0] = digit_image(bcd_digits[4*i +: 4]);
                  end
               end
            end
            MODE_TOGGLE: begin
               for (int i = 0; i < MAX_DIGITS; i++) begin
                  if (dot_operand == 8'(i)) begin
                     store_in[i][DOT_POS] = !store_ff[i][DOT_POS];
                  end
               end
            end
            MODE_SET: begin
               for (int i = 0; i < BCD_LANES; i++) begin
                  if (dot_operand[i]) begin
                     store_in[i][DOT_POS] = 1'b1;
                  end
               end
            end
            MODE_CLEAR: begin
               for (int i = 0; i < BCD_LANES; i++) begin
                  if (dot_operand[i]) begin
                     store_in[i][DOT_POS] = 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // output register next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      seg_in       = seg_ff;
      dsel_in      = dsel_ff;
      if (req_fire && is_refresh) begin
         rsp_valid_in = 1'b1;
         seg_in       = seg_show;
         dsel_in      = 3'(act_next);
      end
   end

   // control and store registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_DIGITS; i++) begin
            store_ff[i] <= 8'd0;
         end
         act_ff       <= IDX_W'(RESET_COUNT - 1);
         bcnt_ff      <= 16'd0;
         dcount_ff    <= CNT_W'(RESET_COUNT);
         bfirst_ff    <= '0;
         blast_ff     <= '0;
         bperiod_ff   <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         store_ff     <= store_in;
         act_ff       <= act_in;
         bcnt_ff      <= bcnt_in;
         dcount_ff    <= dcount_in;
         bfirst_ff    <= bfirst_in;
         blast_ff     <= blast_in;
         bperiod_ff   <= bperiod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      seg_ff  <= seg_in;
      dsel_ff <= dsel_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, dsel_ff, seg_ff};

   // scan index stays below the digit count
   `ASSERT_RST(a_act_range, clock, reset, CNT_W'(act_ff) < dcount_ff, "scan index past digit count")
   // digit count stays within one and the store depth
   `ASSERT_RST(a_count_range, clock, reset,
      dcount_ff != '0 && dcount_ff <= CNT_W'(MAX_DIGITS), "digit count out of range")
   // blink counter stays below a nonzero period
   `ASSERT_RST(a_blink_range, clock, reset,
      bperiod_ff != 16'd0 |-> bcnt_ff < bperiod_ff, "blink counter past period")
   // a new result word only follows a taken refresh word
   `ASSERT_RST(a_rsp_src, clock, reset,
      rsp_valid_ff && !$past(rsp_valid_ff && !rsp_tready) |->
         $past(req_fire && is_refresh), "result word without refresh")

endmodule
